@@ rtl/fkin_pkg.sv @@
// Shared types, constants and helper functions for the seven-joint forward kinematics block.
// Used by fkin_sincos_lane, fkin_row, fkin_chain and the top level. No dependencies.
package fkin_pkg;

	// internal fixed point value, Q30, signed
	typedef logic signed [32:0] q30_t;

	localparam q30_t ONE = 33'sd1073741824;

	// multiples of pi/2 in Q30, wide enough for the doubled input angle
	localparam logic signed [34:0] HP1 = 35'sd1686629713;
	localparam logic signed [34:0] HP3 = 35'sd5059889139;
	localparam logic signed [34:0] HP5 = 35'sd8433148565;

	localparam int NUM_JOINTS = 7;
	localparam logic [3:0] LAST_STEP = 4'd10;
	localparam logic [2:0] LAST_LINK = 3'd7;
	localparam logic [3:0] LAST_OP = 4'd8;
	localparam logic [2:0] NUM_ISSUE = 3'd7;

	// sine/cosine micro-step operand and destination codes
	typedef enum logic {OPA_R, OPA_R2} opa_t;
	typedef enum logic [1:0] {OPB_R, OPB_T, OPB_ONE} opb_t;
	typedef enum logic [1:0] {DST_R2, DST_T, DST_S, DST_C} dst_t;

	typedef struct packed {
		opa_t a_sel;
		opb_t b_sel;
		logic div_en;
		logic [6:0] k;
		logic [31:0] m;
		dst_t dst;
	} lane_step_t;

	// chain row accumulator targets
	typedef enum logic [1:0] {TGT_Z0, TGT_Z1, TGT_ZT} tgt_t;

	// one link of the modified DH table, alpha as sin/cos in {-1,0,1}
	typedef struct packed {
		logic signed [1:0] sa;
		logic signed [1:0] ca;
		q30_t la;
		q30_t ty;
		q30_t tz;
	} link_t;

	// control from the chain sequencer to the row lanes
	typedef struct packed {
		logic init;
		logic issue;
		logic [2:0] op;
		logic commit;
	} row_ctl_t;

	// magnitude of a Q30 value
	function automatic logic [31:0] mag(input q30_t v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	// round a magnitude product back to Q30, half away from zero, and apply sign
	function automatic q30_t qm_fin(input logic [63:0] prod, input logic neg);
		logic [64:0] s;
		q30_t p;
		s = {1'b0, prod} + 65'd536870912;
		p = s[62:30];
		return neg ? -p : p;
	endfunction

	// Q30 to Q2.16 output, rounded half away from zero and saturated
	function automatic logic [17:0] to_out(input q30_t v);
		logic [32:0] m;
		logic [18:0] q;
		logic signed [19:0] qs;
		logic [17:0] r;
		m = {1'b0, mag(v)} + 33'd8192;
		q = m[32:14];
		qs = v[32] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (qs > 20'sd131071) begin
			r = 18'h1FFFF;
		end else if (qs < -20'sd131072) begin
			r = 18'h20000;
		end else begin
			r = qs[17:0];
		end
		return r;
	endfunction

	// sine/cosine polynomial schedule; m is floor(2^32 / k)
	function automatic lane_step_t lane_step(input logic [3:0] step);
		lane_step_t s;
		s = '{a_sel: OPA_R2, b_sel: OPB_T, div_en: 1'b1, k: 7'd1, m: 32'd0, dst: DST_T};
		unique case (step)
			4'd0: s = '{OPA_R, OPB_R, 1'b0, 7'd1, 32'd0, DST_R2};
			4'd1: s = '{OPA_R2, OPB_ONE, 1'b1, 7'd72, 32'd59652323, DST_T};
			4'd2: s = '{OPA_R2, OPB_T, 1'b1, 7'd42, 32'd102261126, DST_T};
			4'd3: s = '{OPA_R2, OPB_T, 1'b1, 7'd20, 32'd214748364, DST_T};
			4'd4: s = '{OPA_R2, OPB_T, 1'b1, 7'd6, 32'd715827882, DST_T};
			4'd5: s = '{OPA_R, OPB_T, 1'b0, 7'd1, 32'd0, DST_S};
			4'd6: s = '{OPA_R2, OPB_ONE, 1'b1, 7'd90, 32'd47721858, DST_T};
			4'd7: s = '{OPA_R2, OPB_T, 1'b1, 7'd56, 32'd76695844, DST_T};
			4'd8: s = '{OPA_R2, OPB_T, 1'b1, 7'd30, 32'd143165576, DST_T};
			4'd9: s = '{OPA_R2, OPB_T, 1'b1, 7'd12, 32'd357913941, DST_T};
			4'd10: s = '{OPA_R2, OPB_T, 1'b1, 7'd2, 32'd2147483648, DST_C};
			default: s = '{OPA_R2, OPB_T, 1'b0, 7'd1, 32'd0, DST_T};
		endcase
		return s;
	endfunction

	// link table: sa, ca, a, -sa*d, ca*d; last entry is the flange
	function automatic link_t link_row(input logic [2:0] idx);
		link_t l;
		l = '{2'sd0, 2'sd1, 33'sd0, 33'sd0, 33'sd0};
		unique case (idx)
			3'd0: l = '{2'sd0, 2'sd1, 33'sd0, 33'sd0, 33'sd357556027};
			3'd1: l = '{-2'sd1, 2'sd0, 33'sd0, 33'sd0, 33'sd0};
			3'd2: l = '{2'sd1, 2'sd0, 33'sd0, -33'sd339302416, 33'sd0};
			3'd3: l = '{2'sd1, 2'sd0, 33'sd88583700, 33'sd0, 33'sd0};
			3'd4: l = '{-2'sd1, 2'sd0, -33'sd88583700, 33'sd412316860, 33'sd0};
			3'd5: l = '{2'sd1, 2'sd0, 33'sd0, 33'sd0, 33'sd0};
			3'd6: l = '{2'sd1, 2'sd0, 33'sd94489281, 33'sd0, 33'sd0};
			3'd7: l = '{2'sd0, 2'sd1, 33'sd0, 33'sd0, 33'sd114890375};
			default: l = '{2'sd0, 2'sd1, 33'sd0, 33'sd0, 33'sd0};
		endcase
		return l;
	endfunction

endpackage

@@ rtl/fkin_sincos_lane.sv @@
// One sine/cosine lane: quadrant reduction and a Taylor polynomial on a shared
// multiplier and constant divider. Depends on fkin_pkg.
module fkin_sincos_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  angle,
	output logic                busy,
	output fkin_pkg::q30_t      sin_v,
	output fkin_pkg::q30_t      cos_v
);

	logic busy_q;
	logic [3:0] step_q;
	logic [1:0] ph_q;

	fkin_pkg::q30_t r_q, r2_q, t_q, s_q, c_q, x_q;
	logic [1:0] quad_q;
	logic [63:0] prod_q;
	logic neg_q;
	logic [30:0] est_q;

	fkin_pkg::lane_step_t st;
	fkin_pkg::q30_t opa, opb, res;
	logic signed [34:0] ang2;
	logic signed [33:0] ang, rfull;
	logic signed [2:0] quad;
	logic [37:0] ek;
	logic [31:0] rem;
	logic [30:0] qt;
	logic [63:0] dprod;

	// quadrant reduction of the incoming angle
	always_comb begin
		ang2 = {angle[15], angle, 18'b0};
		ang = {angle[15], angle, 17'b0};
		if (ang2 > fkin_pkg::HP5) begin
			quad = 3'sd3;
		end else if (ang2 > fkin_pkg::HP3) begin
			quad = 3'sd2;
		end else if (ang2 > fkin_pkg::HP1) begin
			quad = 3'sd1;
		end else if (ang2 < -fkin_pkg::HP5) begin
			quad = -3'sd3;
		end else if (ang2 < -fkin_pkg::HP3) begin
			quad = -3'sd2;
		end else if (ang2 < -fkin_pkg::HP1) begin
			quad = -3'sd1;
		end else begin
			quad = 3'sd0;
		end
		case (quad)
			3'sd3: rfull = ang - 34'(fkin_pkg::HP3);
			3'sd2: rfull = ang - 34'(fkin_pkg::HP1 <<< 1);
			3'sd1: rfull = ang - 34'(fkin_pkg::HP1);
			-3'sd1: rfull = ang + 34'(fkin_pkg::HP1);
			-3'sd2: rfull = ang + 34'(fkin_pkg::HP1 <<< 1);
			-3'sd3: rfull = ang + 34'(fkin_pkg::HP3);
			default: rfull = ang;
		endcase
	end

	// operand selection and divider correction
	always_comb begin
		st = fkin_pkg::lane_step(step_q);
		opa = (st.a_sel == fkin_pkg::OPA_R) ? r_q : r2_q;
		case (st.b_sel)
			fkin_pkg::OPB_R: opb = r_q;
			fkin_pkg::OPB_T: opb = t_q;
			default: opb = fkin_pkg::ONE;
		endcase
		dprod = {33'b0, x_q[30:0]} * {32'b0, st.m};
		ek = {7'b0, est_q} * {31'b0, st.k};
		rem = {1'b0, x_q[30:0]} - ek[31:0];
		qt = (rem >= {25'b0, st.k}) ? est_q + 31'd1 : est_q;
		res = st.div_en ? fkin_pkg::ONE - $signed({2'b0, qt}) : x_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			ph_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			ph_q <= '0;
		end else if (busy_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3) begin
				if (step_q == fkin_pkg::LAST_STEP) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// datapath: multiply, round, reciprocal estimate, correct and write back
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= rfull[32:0];
			quad_q <= quad[1:0];
		end else if (busy_q) begin
			case (ph_q)
				2'd0: begin
					prod_q <= {32'b0, fkin_pkg::mag(opa)} * {32'b0, fkin_pkg::mag(opb)};
					neg_q <= opa[32] ^ opb[32];
				end
				2'd1: x_q <= fkin_pkg::qm_fin(prod_q, neg_q);
				2'd2: est_q <= dprod[62:32];
				default: begin
					case (st.dst)
						fkin_pkg::DST_R2: r2_q <= res;
						fkin_pkg::DST_T: t_q <= res;
						fkin_pkg::DST_S: s_q <= res;
						default: c_q <= res;
					endcase
				end
			endcase
		end
	end

	// quadrant mapping
	always_comb begin
		case (quad_q)
			2'd0: begin sin_v = s_q; cos_v = c_q; end
			2'd1: begin sin_v = c_q; cos_v = -s_q; end
			2'd2: begin sin_v = -s_q; cos_v = -c_q; end
			default: begin sin_v = -c_q; cos_v = s_q; end
		endcase
	end

	assign busy = busy_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("lane restarted while busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= fkin_pkg::LAST_STEP) else $error("lane step out of range");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && step_q == 4'd0 && ph_q == 2'd0) else $error("lane did not start");

endmodule

@@ rtl/fkin_row.sv @@
// One row lane of the transform chain: multiplies its row of the running pose
// by the current link transform. Depends on fkin_pkg.
module fkin_row (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           row_idx,
	input  fkin_pkg::row_ctl_t   ctl,
	input  fkin_pkg::q30_t       ct,
	input  fkin_pkg::q30_t       st,
	input  fkin_pkg::link_t      lnk,
	output fkin_pkg::q30_t       r0,
	output fkin_pkg::q30_t       r1,
	output fkin_pkg::q30_t       r2,
	output fkin_pkg::q30_t       tr
);

	fkin_pkg::q30_t a0_q, a1_q, a2_q, t_q, z0_q, z1_q, zt_q;
	logic vld_s1;
	logic [63:0] prod_s1;
	logic neg_s1;
	fkin_pkg::tgt_t tgt_s1;

	fkin_pkg::q30_t ak, opa, opb, term, z2;
	logic kneg, flip;
	fkin_pkg::tgt_t tgt;

	// operand schedule for one link
	always_comb begin
		ak = (lnk.ca != 2'sd0) ? a1_q : a2_q;
		kneg = (lnk.ca != 2'sd0) ? lnk.ca[1] : lnk.sa[1];
		opa = a0_q;
		opb = ct;
		flip = 1'b0;
		tgt = fkin_pkg::TGT_Z0;
		case (ctl.op)
			3'd0: begin opa = a0_q; opb = ct; end
			3'd1: begin opa = ak; opb = st; flip = kneg; end
			3'd2: begin opa = a0_q; opb = st; flip = 1'b1; tgt = fkin_pkg::TGT_Z1; end
			3'd3: begin opa = ak; opb = ct; flip = kneg; tgt = fkin_pkg::TGT_Z1; end
			3'd4: begin opa = a0_q; opb = lnk.la; tgt = fkin_pkg::TGT_ZT; end
			3'd5: begin opa = a1_q; opb = lnk.ty; tgt = fkin_pkg::TGT_ZT; end
			default: begin opa = a2_q; opb = lnk.tz; tgt = fkin_pkg::TGT_ZT; end
		endcase
		term = fkin_pkg::qm_fin(prod_s1, neg_s1);
		z2 = '0;
		if (lnk.sa == 2'sd1) begin
			z2 = -a1_q;
		end else if (lnk.sa == -2'sd1) begin
			z2 = a1_q;
		end
		if (lnk.ca == 2'sd1) begin
			z2 = z2 + a2_q;
		end else if (lnk.ca == -2'sd1) begin
			z2 = z2 - a2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
		end
	end

	// product stage, accumulation and commit
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= {32'b0, fkin_pkg::mag(opa)} * {32'b0, fkin_pkg::mag(opb)};
			neg_s1 <= opa[32] ^ opb[32] ^ flip;
			tgt_s1 <= tgt;
		end
		if (ctl.init) begin
			a0_q <= (row_idx == 2'd0) ? fkin_pkg::ONE : '0;
			a1_q <= (row_idx == 2'd1) ? fkin_pkg::ONE : '0;
			a2_q <= (row_idx == 2'd2) ? fkin_pkg::ONE : '0;
			t_q <= '0;
			zt_q <= '0;
			z0_q <= '0;
			z1_q <= '0;
		end else if (ctl.commit) begin
			a0_q <= z0_q;
			a1_q <= z1_q;
			a2_q <= z2;
			t_q <= zt_q;
			z0_q <= '0;
			z1_q <= '0;
		end else if (vld_s1) begin
			case (tgt_s1)
				fkin_pkg::TGT_Z0: z0_q <= z0_q + term;
				fkin_pkg::TGT_Z1: z1_q <= z1_q + term;
				default: zt_q <= zt_q + term;
			endcase
		end
	end

	assign r0 = a0_q;
	assign r1 = a1_q;
	assign r2 = a2_q;
	assign tr = t_q;

endmodule

@@ rtl/fkin_chain.sv @@
// Transform chain and merge: sequences the eight links over three row lanes,
// converts the end pose and holds it in the output register. Depends on fkin_pkg, fkin_row.
module fkin_chain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  fkin_pkg::q30_t  sin_in [fkin_pkg::NUM_JOINTS],
	input  fkin_pkg::q30_t  cos_in [fkin_pkg::NUM_JOINTS],
	output logic            busy,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [215:0]    m_tdata
);

	fkin_pkg::q30_t sin_q [fkin_pkg::NUM_JOINTS];
	fkin_pkg::q30_t cos_q [fkin_pkg::NUM_JOINTS];
	logic busy_q, fin_q, mvalid_q;
	logic [2:0] link_q;
	logic [3:0] op_q;
	logic [215:0] mdata_q;

	fkin_pkg::row_ctl_t ctl;
	fkin_pkg::q30_t ct, st;
	fkin_pkg::link_t lnk;
	fkin_pkg::q30_t rv [3][3];
	fkin_pkg::q30_t tv [3];
	logic out_free, load;
	logic [215:0] packed_res;

	// link operands
	always_comb begin
		lnk = fkin_pkg::link_row(link_q);
		if (link_q == fkin_pkg::LAST_LINK) begin
			st = '0;
			ct = fkin_pkg::ONE;
		end else begin
			st = sin_q[link_q];
			ct = cos_q[link_q];
		end
		ctl.init = start;
		ctl.issue = busy_q && !fin_q && (op_q < {1'b0, fkin_pkg::NUM_ISSUE});
		ctl.op = op_q[2:0];
		ctl.commit = busy_q && !fin_q && (op_q == fkin_pkg::LAST_OP);
		out_free = !mvalid_q || m_tready;
		load = fin_q && out_free;
	end

	for (genvar g = 0; g < 3; g++) begin : g_row
		fkin_row u_row (
			.clk     (clk),
			.arst_n  (arst_n),
			.row_idx (2'(g)),
			.ctl     (ctl),
			.ct      (ct),
			.st      (st),
			.lnk     (lnk),
			.r0      (rv[g][0]),
			.r1      (rv[g][1]),
			.r2      (rv[g][2]),
			.tr      (tv[g])
		);
	end

	// output conversion, rotation row-major then translation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				packed_res[18*(3*i+j) +: 18] = fkin_pkg::to_out(rv[i][j]);
			end
			packed_res[18*(9+i) +: 18] = fkin_pkg::to_out(tv[i]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			link_q <= '0;
			op_q <= '0;
			mvalid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				fin_q <= 1'b0;
				link_q <= '0;
				op_q <= '0;
			end else if (load) begin
				busy_q <= 1'b0;
				fin_q <= 1'b0;
			end else if (busy_q && !fin_q) begin
				if (op_q == fkin_pkg::LAST_OP) begin
					op_q <= '0;
					if (link_q == fkin_pkg::LAST_LINK) begin
						fin_q <= 1'b1;
					end else begin
						link_q <= link_q + 3'd1;
					end
				end else begin
					op_q <= op_q + 4'd1;
				end
			end
			if (load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sin_q <= sin_in;
			cos_q <= cos_in;
		end
		if (load) begin
			mdata_q <= packed_res;
		end
	end

	assign busy = busy_q;
	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> busy_q) else $error("finish flag without busy");
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> op_q <= fkin_pkg::LAST_OP) else $error("chain op out of range");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("chain restarted while busy");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> mvalid_q) else $error("result not presented");

endmodule

@@ rtl/arm_forward_kinematics_7dof_unit.sv @@
// Top level of the seven-joint forward kinematics block: seven sine/cosine
// lanes feeding the transform chain. Depends on fkin_pkg, fkin_sincos_lane, fkin_chain.
//
// channel  dir  width  contents
// s_*      in   112    seven joint angles, Q3.13 rad
// m_*      out  216    rotation r0c0..r2c2, position x,y,z, Q2.16
//
// The lanes hand a request to the chain once they are done with it and the chain is free.
// The chain works through the eight links, then loads the output register, and
// can start again once it has. Its shared row multipliers take one request at a
// time, so the lanes can work on the next request while the chain is busy. A new
// request is taken as soon as the lanes have handed their results to the chain.
// Reset clears all control state; a stalled result holds in the output register
// while the chain may finish the next one and wait behind it.
module arm_forward_kinematics_7dof_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,   // angle_joint1 .. angle_joint7, 16 bits each
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [215:0]  m_tdata    // rot_r0c0..rot_r2c2, pos_x, pos_y, pos_z, 18 bits each
);

	logic lane_hold_q;
	logic accept, chain_start, chain_busy;
	logic [fkin_pkg::NUM_JOINTS-1:0] lane_busy;
	fkin_pkg::q30_t sin_v [fkin_pkg::NUM_JOINTS];
	fkin_pkg::q30_t cos_v [fkin_pkg::NUM_JOINTS];

	assign s_tready = !lane_hold_q;
	assign accept = s_tvalid && s_tready;
	assign chain_start = lane_hold_q && !lane_busy[0] && !chain_busy;

	// one lane per joint
	for (genvar g = 0; g < fkin_pkg::NUM_JOINTS; g++) begin : g_lane
		fkin_sincos_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.angle  (s_tdata[16*g +: 16]),
			.busy   (lane_busy[g]),
			.sin_v  (sin_v[g]),
			.cos_v  (cos_v[g])
		);
	end

	// lanes hold their results until the chain takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_hold_q <= 1'b0;
		end else if (accept) begin
			lane_hold_q <= 1'b1;
		end else if (chain_start) begin
			lane_hold_q <= 1'b0;
		end
	end

	fkin_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (chain_start),
		.sin_in   (sin_v),
		.cos_in   (cos_v),
		.busy     (chain_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_busy == '0 || lane_busy == '1) else $error("lanes out of step");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> lane_busy[0] && lane_hold_q) else $error("lanes not started");
	a_busy_held: assert property (@(posedge clk) disable iff (!arst_n)
		lane_busy[0] |-> lane_hold_q) else $error("lanes busy without request");

endmodule
